// ----- hw/rtl/sspg_pkg.sv -----
// Shared types and constants for the step/direction pulse generator.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package sspg_pkg;

  // field widths
  localparam int CmdW      = 3;
  localparam int CountW    = 32;
  localparam int IntervalW = 20;
  localparam int OutcomeW  = 3;

  // interval register limits and reset value
  localparam logic [IntervalW-1:0] IntervalMin   = 20'd50;
  localparam logic [IntervalW-1:0] IntervalReset = 20'd1000;

  // ticks between the direction level and the first pulse (1 to 1048575)
  localparam logic [IntervalW-1:0] DirSetupTicks = 20'd10;

  // command codes; six and seven are ignored
  typedef enum logic [CmdW-1:0] {
    CMD_TICK      = 3'd0,
    CMD_ENABLE    = 3'd1,
    CMD_DISABLE   = 3'd2,
    CMD_MOVE      = 3'd3,
    CMD_RESET_POS = 3'd4,
    CMD_ABORT     = 3'd5
  } cmd_t;

  // outcome codes reported with each result word
  typedef enum logic [OutcomeW-1:0] {
    OUT_NONE        = 3'd0,
    OUT_ACCEPTED    = 3'd1,
    OUT_DONE        = 3'd2,
    OUT_ABORTED     = 3'd3,
    OUT_NOT_ENABLED = 3'd4,
    OUT_BUSY        = 3'd5
  } outcome_t;

  // move sequencer phases
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SETUP = 2'd1,
    PH_HIGH  = 2'd2,
    PH_LOW   = 2'd3
  } phase_t;

endpackage

// ----- hw/rtl/sspg_intf.sv -----
// Valid/ready channel interfaces for the command and result words.
// Depends on sspg_pkg for field widths.
`timescale 1ns / 1ps

// command channel: tick or command plus signed step count
interface sspg_req_if;
  logic                                valid;
  logic                                ready;
  logic [sspg_pkg::CmdW-1:0]           command;
  logic signed [sspg_pkg::CountW-1:0]  step_count;

  modport source (output valid, output command, output step_count, input ready);
  modport sink   (input valid, input command, input step_count, output ready);
endinterface

// result channel: pin levels, position and move status
interface sspg_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                enable_n;
  logic                                direction;
  logic                                pulse;
  logic signed [sspg_pkg::CountW-1:0]  position;
  logic                                busy_res;
  logic [sspg_pkg::OutcomeW-1:0]       outcome;

  modport source (output valid, output enable_n, output direction, output pulse,
                  output position, output busy_res, output outcome, input ready);
  modport sink   (input valid, input enable_n, input direction, input pulse,
                  input position, input busy_res, input outcome, output ready);
endinterface

// ----- hw/rtl/stepper_step_dir_pulse_generator.sv -----
// Step/direction pulse generator: top level with the move sequencer.
// Depends on sspg_pkg and the channel interfaces in sspg_intf.sv.
`timescale 1ns / 1ps

// Takes one word per clock cycle unless rsp stalls: each word is either a
// timebase tick or a command (enable, disable, move, reset position, abort),
// and each gives exactly one result word with the enable, direction and step
// pin levels, the position and the move status. The whole update is one pass
// of logic from the state registers into a single output register, so a word
// is accepted in every cycle in which the output register is empty or being
// taken; req.ready follows rsp.ready combinationally. The result word is
// registered. A move drives the direction level, waits ten ticks, then gives
// one pulse per step, high for step_interval/2 ticks and low for as long;
// the position changes at the end of each low half. step_interval writes
// below 50 are dropped, and a new value applies from the next phase that
// starts. Nothing needs clearing after reset.

module stepper_step_dir_pulse_generator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step_interval_we,
  input  logic [sspg_pkg::IntervalW-1:0]     step_interval_wdata,
  sspg_req_if.sink                           req,
  sspg_rsp_if.source                         rsp
);

  // architectural state
  logic [sspg_pkg::IntervalW-1:0]  step_interval;
  logic                            enabled_flag;
  logic [sspg_pkg::CountW-1:0]     position_count;
  logic                            moving;
  logic                            forward_dir;
  logic [sspg_pkg::CountW-1:0]     steps_left;
  sspg_pkg::phase_t                phase;
  logic [sspg_pkg::IntervalW-1:0]  phase_ticks;

  logic                            enabled_flag_next;
  logic [sspg_pkg::CountW-1:0]     position_count_next;
  logic                            moving_next;
  logic                            forward_dir_next;
  logic [sspg_pkg::CountW-1:0]     steps_left_next;
  sspg_pkg::phase_t                phase_next;
  logic [sspg_pkg::IntervalW-1:0]  phase_ticks_next;
  sspg_pkg::outcome_t              outcome_next;
  logic                            pulse_next;

  logic                            accept;
  logic [sspg_pkg::IntervalW-1:0]  half_period;
  logic [sspg_pkg::IntervalW-1:0]  ticks_dec;
  logic [sspg_pkg::CountW-1:0]     steps_dec;
  logic [sspg_pkg::CountW-1:0]     step_mag;

  // output register frees up when empty or being taken
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign half_period = step_interval >> 1;
  assign ticks_dec   = (phase_ticks != '0) ? phase_ticks - 1'b1 : '0;
  assign steps_dec   = (steps_left != '0) ? steps_left - 1'b1 : '0;
  assign step_mag    = req.step_count[sspg_pkg::CountW-1] ?
                       (~req.step_count + 1'b1) : req.step_count;

  // next state for one word
  always_comb begin
    enabled_flag_next   = enabled_flag;
    position_count_next = position_count;
    moving_next         = moving;
    forward_dir_next    = forward_dir;
    steps_left_next     = steps_left;
    phase_next          = phase;
    phase_ticks_next    = phase_ticks;
    outcome_next        = sspg_pkg::OUT_NONE;

    unique case (sspg_pkg::cmd_t'(req.command))
      sspg_pkg::CMD_TICK: begin
        if (moving) begin
          phase_ticks_next = ticks_dec;
          if (ticks_dec == '0) begin
            unique case (phase)
              sspg_pkg::PH_SETUP: begin
                phase_next       = sspg_pkg::PH_HIGH;
                phase_ticks_next = half_period;
              end
              sspg_pkg::PH_HIGH: begin
                phase_next       = sspg_pkg::PH_LOW;
                phase_ticks_next = half_period;
              end
              sspg_pkg::PH_LOW: begin
                position_count_next = forward_dir ? position_count + 1'b1
                                                  : position_count - 1'b1;
                if (steps_dec == '0) begin
                  moving_next      = 1'b0;
                  phase_next       = sspg_pkg::PH_IDLE;
                  phase_ticks_next = '0;
                  steps_left_next  = '0;
                  outcome_next     = sspg_pkg::OUT_DONE;
                end else begin
                  steps_left_next  = steps_dec;
                  phase_next       = sspg_pkg::PH_HIGH;
                  phase_ticks_next = half_period;
                end
              end
              default: begin
                moving_next      = 1'b0;
                phase_next       = sspg_pkg::PH_IDLE;
                phase_ticks_next = '0;
                steps_left_next  = '0;
              end
            endcase
          end
        end
      end
      sspg_pkg::CMD_ABORT: begin
        if (moving) begin
          moving_next      = 1'b0;
          phase_next       = sspg_pkg::PH_IDLE;
          phase_ticks_next = '0;
          steps_left_next  = '0;
          outcome_next     = sspg_pkg::OUT_ABORTED;
        end
      end
      sspg_pkg::CMD_ENABLE: begin
        if (moving) begin
          outcome_next = sspg_pkg::OUT_BUSY;
        end else begin
          enabled_flag_next = 1'b1;
          outcome_next      = sspg_pkg::OUT_ACCEPTED;
        end
      end
      sspg_pkg::CMD_DISABLE: begin
        if (moving) begin
          outcome_next = sspg_pkg::OUT_BUSY;
        end else begin
          enabled_flag_next = 1'b0;
          outcome_next      = sspg_pkg::OUT_ACCEPTED;
        end
      end
      sspg_pkg::CMD_RESET_POS: begin
        if (moving) begin
          outcome_next = sspg_pkg::OUT_BUSY;
        end else begin
          position_count_next = '0;
          outcome_next        = sspg_pkg::OUT_ACCEPTED;
        end
      end
      sspg_pkg::CMD_MOVE: begin
        priority if (moving) begin
          outcome_next = sspg_pkg::OUT_BUSY;
        end else if (!enabled_flag) begin
          outcome_next = sspg_pkg::OUT_NOT_ENABLED;
        end else if (req.step_count == '0) begin
          outcome_next = sspg_pkg::OUT_DONE;
        end else begin
          forward_dir_next = !req.step_count[sspg_pkg::CountW-1];
          steps_left_next  = step_mag;
          moving_next      = 1'b1;
          phase_next       = sspg_pkg::PH_SETUP;
          phase_ticks_next = sspg_pkg::DirSetupTicks;
          outcome_next     = sspg_pkg::OUT_ACCEPTED;
        end
      end
      default: begin
        // undefined codes leave everything as is
      end
    endcase
  end

  // pin level seen after this word
  always_comb begin
    pulse_next = moving_next && (phase_next == sspg_pkg::PH_HIGH);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled_flag   <= 1'b0;
      position_count <= '0;
      moving         <= 1'b0;
      forward_dir    <= 1'b0;
      steps_left     <= '0;
      phase          <= sspg_pkg::PH_IDLE;
      phase_ticks    <= '0;
    end else if (accept) begin
      enabled_flag   <= enabled_flag_next;
      position_count <= position_count_next;
      moving         <= moving_next;
      forward_dir    <= forward_dir_next;
      steps_left     <= steps_left_next;
      phase          <= phase_next;
      phase_ticks    <= phase_ticks_next;
    end
  end

  // interval register, short values dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      step_interval <= sspg_pkg::IntervalReset;
    end else if (step_interval_we && step_interval_wdata >= sspg_pkg::IntervalMin) begin
      step_interval <= step_interval_wdata;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.enable_n  <= !enabled_flag_next;
      rsp.direction <= forward_dir_next;
      rsp.pulse     <= pulse_next;
      rsp.position  <= position_count_next;
      rsp.busy_res  <= moving_next;
      rsp.outcome   <= outcome_next;
    end
  end

  // checks
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !moving |-> (phase == sspg_pkg::PH_IDLE && steps_left == '0 && phase_ticks == '0))
    else $error("idle sequencer holds leftover move state");

  a_moving_phase: assert property (@(posedge clk) disable iff (rst)
    moving |-> (phase != sspg_pkg::PH_IDLE && steps_left != '0))
    else $error("move in progress without phase or steps");

  a_interval_floor: assert property (@(posedge clk) disable iff (rst)
    step_interval >= sspg_pkg::IntervalMin)
    else $error("step interval below floor");

  a_pulse_busy: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.pulse) |-> rsp.busy_res)
    else $error("step pulse reported without a move");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && outcome_next == sspg_pkg::OUT_DONE) |=> !moving)
    else $error("move done but sequencer still busy");

endmodule

// ----- tb/sv/tb_stepper_step_dir_pulse_generator.sv -----
// Self-checking testbench for the step/direction pulse generator.
// Depends on sspg_pkg, the channel interfaces in sspg_intf.sv and the top level;
// it predicts every result word in step with the command words it sends.
`timescale 1ns / 1ps

module tb_stepper_step_dir_pulse_generator;

  typedef logic [sspg_pkg::CmdW-1:0]      cmd_bits_t;
  typedef logic [sspg_pkg::IntervalW-1:0] ival_bits_t;

  // command codes that the block ignores
  localparam cmd_bits_t CMD_SPARE_A = 3'd6;
  localparam cmd_bits_t CMD_SPARE_B = 3'd7;

  localparam int RandomWords = 250;
  localparam int HoldCycles  = 150;
  localparam int MaxReports  = 10;
  localparam int IdlePct     = 22;

  typedef struct packed {
    logic                               enable_n;
    logic                               direction;
    logic                               pulse;
    logic signed [sspg_pkg::CountW-1:0] position;
    logic                               busy;
    sspg_pkg::outcome_t                 outcome;
  } pin_word_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  ival_bits_t cfg_wdata;

  sspg_req_if req ();
  sspg_rsp_if rsp ();

  stepper_step_dir_pulse_generator dut (
    .clk                 (clk),
    .rst                 (rst),
    .step_interval_we    (cfg_we),
    .step_interval_wdata (cfg_wdata),
    .req                 (req),
    .rsp                 (rsp)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predicted block state
  ival_bits_t                  mdl_interval;
  logic                        mdl_enabled;
  logic [sspg_pkg::CountW-1:0] mdl_pos;
  logic                        mdl_moving;
  logic                        mdl_fwd;
  logic [sspg_pkg::CountW-1:0] mdl_steps;
  sspg_pkg::phase_t            mdl_phase;
  ival_bits_t                  mdl_ticks;

  // expected result words, oldest first
  pin_word_t pins_due[$];

  int  mismatches = 0;
  int  words_counted = 0;
  int  moves_done = 0;
  int  moves_aborted = 0;
  int  busy_rejects = 0;
  int  interval_writes = 0;
  int  tx_calm = 0;
  int  hold_asked = 0;

  function automatic void stop_model_move();
    mdl_moving = 1'b0;
    mdl_phase  = sspg_pkg::PH_IDLE;
    mdl_ticks  = '0;
    mdl_steps  = '0;
  endfunction

  // one timebase tick of a running move
  function automatic sspg_pkg::outcome_t model_tick();
    if (mdl_ticks != 0) mdl_ticks--;
    if (mdl_ticks != 0) return sspg_pkg::OUT_NONE;
    case (mdl_phase)
      sspg_pkg::PH_SETUP: begin
        mdl_phase = sspg_pkg::PH_HIGH;
        mdl_ticks = mdl_interval >> 1;
        return sspg_pkg::OUT_NONE;
      end
      sspg_pkg::PH_HIGH: begin
        mdl_phase = sspg_pkg::PH_LOW;
        mdl_ticks = mdl_interval >> 1;
        return sspg_pkg::OUT_NONE;
      end
      sspg_pkg::PH_LOW: begin
        mdl_pos = mdl_fwd ? mdl_pos + 1 : mdl_pos - 1;
        if (mdl_steps != 0) mdl_steps--;
        if (mdl_steps == 0) begin
          stop_model_move();
          return sspg_pkg::OUT_DONE;
        end
        mdl_phase = sspg_pkg::PH_HIGH;
        mdl_ticks = mdl_interval >> 1;
        return sspg_pkg::OUT_NONE;
      end
      default: begin
        stop_model_move();
        return sspg_pkg::OUT_NONE;
      end
    endcase
  endfunction

  // advance the predicted state by one word and return the pins it leaves
  function automatic pin_word_t predict_pins(input cmd_bits_t code,
                                             input logic [sspg_pkg::CountW-1:0] cnt);
    pin_word_t          w;
    sspg_pkg::outcome_t res;
    res = sspg_pkg::OUT_NONE;
    case (code)
      sspg_pkg::CMD_TICK: if (mdl_moving) res = model_tick();
      sspg_pkg::CMD_ABORT: begin
        if (mdl_moving) begin
          stop_model_move();
          res = sspg_pkg::OUT_ABORTED;
        end
      end
      sspg_pkg::CMD_ENABLE, sspg_pkg::CMD_DISABLE, sspg_pkg::CMD_MOVE,
      sspg_pkg::CMD_RESET_POS: begin
        if (mdl_moving) begin
          res = sspg_pkg::OUT_BUSY;
        end else if (code == sspg_pkg::CMD_ENABLE) begin
          mdl_enabled = 1'b1;
          res = sspg_pkg::OUT_ACCEPTED;
        end else if (code == sspg_pkg::CMD_DISABLE) begin
          mdl_enabled = 1'b0;
          res = sspg_pkg::OUT_ACCEPTED;
        end else if (code == sspg_pkg::CMD_RESET_POS) begin
          mdl_pos = '0;
          res = sspg_pkg::OUT_ACCEPTED;
        end else if (!mdl_enabled) begin
          res = sspg_pkg::OUT_NOT_ENABLED;
        end else if (cnt == 0) begin
          res = sspg_pkg::OUT_DONE;
        end else begin
          mdl_fwd    = !cnt[sspg_pkg::CountW-1];
          mdl_steps  = cnt[sspg_pkg::CountW-1] ? -cnt : cnt;
          mdl_moving = 1'b1;
          mdl_phase  = sspg_pkg::PH_SETUP;
          mdl_ticks  = (sspg_pkg::DirSetupTicks == '0) ? 20'd1 : sspg_pkg::DirSetupTicks;
          res = sspg_pkg::OUT_ACCEPTED;
        end
      end
      default: ;
    endcase
    w.enable_n  = !mdl_enabled;
    w.direction = mdl_fwd;
    w.pulse     = mdl_moving && (mdl_phase == sspg_pkg::PH_HIGH);
    w.position  = mdl_pos;
    w.busy      = mdl_moving;
    w.outcome   = res;
    return w;
  endfunction

  // offer one word, with random idle cycles ahead of it, and predict its result
  task automatic send_word(input cmd_bits_t code,
                           input logic [sspg_pkg::CountW-1:0] cnt);
    pin_word_t w;
    while (tx_calm == 0 && $urandom_range(0, 99) < IdlePct) begin
      @(negedge clk);
      req.valid <= 1'b0;
    end
    if (tx_calm > 0) tx_calm--;
    @(negedge clk);
    req.valid      <= 1'b1;
    req.command    <= code;
    req.step_count <= cnt;
    do @(posedge clk); while (!req.ready);
    if (!((code == sspg_pkg::CMD_TICK && !mdl_moving) || code > sspg_pkg::CMD_ABORT))
      words_counted++;
    w = predict_pins(code, cnt);
    case (w.outcome)
      sspg_pkg::OUT_DONE:    moves_done++;
      sspg_pkg::OUT_ABORTED: moves_aborted++;
      sspg_pkg::OUT_BUSY:    busy_rejects++;
      default: ;
    endcase
    pins_due.push_back(w);
  endtask

  // stop offering and wait until every predicted word has come back
  task automatic wait_drained();
    @(negedge clk);
    req.valid <= 1'b0;
    while (pins_due.size() != 0) @(posedge clk);
  endtask

  // interval register write, only with the channels quiet
  task automatic write_interval(input ival_bits_t val);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (val >= sspg_pkg::IntervalMin) mdl_interval = val;
    interval_writes++;
  endtask

  task automatic run_ticks(input int n);
    repeat (n) send_word(sspg_pkg::CMD_TICK, $urandom);
  endtask

  task automatic finish_move();
    while (mdl_moving) send_word(sspg_pkg::CMD_TICK, $urandom);
  endtask

  // commands and ticks with nothing moving, plus the ignored codes
  task automatic test_idle_commands();
    send_word(sspg_pkg::CMD_TICK, '0);
    send_word(sspg_pkg::CMD_ABORT, '1);
    send_word(CMD_SPARE_A, 32'h5555_5555);
    send_word(CMD_SPARE_B, 32'hAAAA_AAAA);
    send_word(sspg_pkg::CMD_MOVE, 32'd5);
    send_word(sspg_pkg::CMD_MOVE, '0);
    send_word(sspg_pkg::CMD_DISABLE, '0);
    send_word(sspg_pkg::CMD_RESET_POS, '0);
    send_word(sspg_pkg::CMD_ENABLE, '0);
    send_word(sspg_pkg::CMD_MOVE, '0);
  endtask

  // short writes are dropped, smallest legal interval is taken
  task automatic test_interval_floor();
    write_interval('0);
    write_interval(sspg_pkg::IntervalMin - 20'd1);
    write_interval(sspg_pkg::IntervalMin);
    send_word(sspg_pkg::CMD_MOVE, 32'd1);
    finish_move();
  endtask

  // reverse move across zero, with commands rejected while it runs
  task automatic test_reverse_wrap();
    send_word(sspg_pkg::CMD_RESET_POS, '0);
    send_word(sspg_pkg::CMD_MOVE, -32'sd1);
    send_word(sspg_pkg::CMD_ENABLE, '0);
    send_word(sspg_pkg::CMD_DISABLE, '0);
    send_word(sspg_pkg::CMD_MOVE, 32'd7);
    send_word(sspg_pkg::CMD_RESET_POS, '0);
    finish_move();
  endtask

  // new interval picked up by the next phase of a running move
  task automatic test_interval_mid_move();
    send_word(sspg_pkg::CMD_MOVE, 32'd3);
    run_ticks(30);
    write_interval(20'd80);
    run_ticks(60);
    write_interval(sspg_pkg::IntervalMin);
    finish_move();
  endtask

  // largest interval and full-range counts, each cut short by abort
  task automatic test_long_moves_abort();
    write_interval('1);
    send_word(sspg_pkg::CMD_MOVE, 32'd2);
    run_ticks(40);
    send_word(sspg_pkg::CMD_ABORT, '0);
    write_interval(sspg_pkg::IntervalMin);
    send_word(sspg_pkg::CMD_MOVE, 32'h8000_0000);
    run_ticks(70);
    send_word(sspg_pkg::CMD_ABORT, '0);
    send_word(sspg_pkg::CMD_MOVE, 32'h7FFF_FFFF);
    while (!(mdl_moving && mdl_phase == sspg_pkg::PH_HIGH))
      send_word(sspg_pkg::CMD_TICK, '0);
    send_word(sspg_pkg::CMD_ABORT, '1);
    send_word(sspg_pkg::CMD_ABORT, '0);
  endtask

  // result side held off while words keep coming, then a full drain pause
  task automatic test_output_backpressure();
    send_word(sspg_pkg::CMD_MOVE, -32'sd2);
    hold_asked++;
    run_ticks(40);
    wait_drained();
    finish_move();
    send_word(sspg_pkg::CMD_DISABLE, '0);
    send_word(sspg_pkg::CMD_MOVE, 32'd4);
    send_word(sspg_pkg::CMD_ENABLE, '0);
  endtask

  // mostly complete moves with random content, the rest noise
  task automatic test_random_traffic();
    int                          pick;
    int                          steps;
    int                          target;
    logic [sspg_pkg::CountW-1:0] cnt;
    target  = words_counted + RandomWords;
    tx_calm = 200;
    while (words_counted < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if (!mdl_enabled) send_word(sspg_pkg::CMD_ENABLE, $urandom);
        if ($urandom_range(0, 3) == 0) write_interval(ival_bits_t'($urandom_range(40, 72)));
        if ($urandom_range(0, 9) == 0) begin
          cnt = $urandom;
        end else begin
          steps = $urandom_range(1, 3);
          cnt = $urandom_range(0, 1) ? -steps : steps;
        end
        send_word(sspg_pkg::CMD_MOVE, cnt);
        while (mdl_moving) begin
          pick = $urandom_range(0, 999);
          if (pick < 30)
            send_word(cmd_bits_t'($urandom_range(sspg_pkg::CMD_ENABLE,
                                                 sspg_pkg::CMD_RESET_POS)), $urandom);
          else if (pick < 36 || (mdl_steps > 8 && pick < 60))
            send_word(sspg_pkg::CMD_ABORT, $urandom);
          else if (pick < 40)
            write_interval(ival_bits_t'($urandom_range(50, 90)));
          else
            send_word(sspg_pkg::CMD_TICK, $urandom);
        end
      end else if (pick < 85) begin
        send_word(cmd_bits_t'($urandom_range(0, 7)), $urandom);
      end else if (pick < 93) begin
        case ($urandom_range(0, 2))
          0: send_word(sspg_pkg::CMD_ENABLE, $urandom);
          1: send_word(sspg_pkg::CMD_DISABLE, $urandom);
          default: send_word(sspg_pkg::CMD_RESET_POS, $urandom);
        endcase
      end else begin
        send_word(sspg_pkg::CMD_MOVE, '0);
      end
    end
  endtask

  // result side: random stalls, a recurring window with ready held high,
  // and a long hold-off when asked for
  initial begin
    int hold_left;
    int hold_seen;
    int rx_cycle;
    hold_left = 0;
    hold_seen = 0;
    rx_cycle  = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (hold_asked != hold_seen) begin
        hold_seen = hold_asked;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (rx_cycle % 3000 < 400) begin
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    pin_word_t want;
    pin_word_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got.enable_n  = rsp.enable_n;
      got.direction = rsp.direction;
      got.pulse     = rsp.pulse;
      got.position  = rsp.position;
      got.busy      = rsp.busy_res;
      got.outcome   = sspg_pkg::outcome_t'(rsp.outcome);
      if (pins_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result word: outcome=%0d position=%0d",
                   got.outcome, got.position);
      end else begin
        want = pins_due.pop_front();
        if (got.enable_n !== want.enable_n || got.direction !== want.direction ||
            got.pulse !== want.pulse || got.position !== want.position ||
            got.busy !== want.busy || got.outcome !== want.outcome) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display({"mismatch: expected en_n=%0b dir=%0b pulse=%0b pos=%0d busy=%0b ",
                      "outcome=%0d, got en_n=%0b dir=%0b pulse=%0b pos=%0d busy=%0b ",
                      "outcome=%0d"},
                     want.enable_n, want.direction, want.pulse, want.position,
                     want.busy, want.outcome, got.enable_n, got.direction, got.pulse,
                     got.position, got.busy, got.outcome);
        end
      end
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAIL stepper_step_dir_pulse_generator");
    $finish;
  end

  initial begin
    int waited;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    req.valid      = 1'b0;
    req.command    = sspg_pkg::CMD_TICK;
    req.step_count = '0;
    mdl_interval   = sspg_pkg::IntervalReset;
    mdl_enabled    = 1'b0;
    mdl_pos        = '0;
    mdl_fwd        = 1'b0;
    stop_model_move();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_commands();
    test_interval_floor();
    test_reverse_wrap();
    test_interval_mid_move();
    test_long_moves_abort();
    test_output_backpressure();
    test_random_traffic();

    // drain, then keep watching for anything stray
    @(negedge clk);
    req.valid <= 1'b0;
    waited = 0;
    while (pins_due.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pins_due.size() != 0) begin
      mismatches++;
      $display("%0d result words never arrived", pins_due.size());
    end

    $display("covered %0d command words: %0d moves done, %0d aborted, %0d busy rejects",
             words_counted, moves_done, moves_aborted, busy_rejects);
    $display("%0d interval writes, long result stall and full drain pause included",
             interval_writes);
    if (mismatches == 0) begin
      $display("PASS stepper_step_dir_pulse_generator");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL stepper_step_dir_pulse_generator");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/sspg_pkg.sv
hw/rtl/sspg_intf.sv
hw/rtl/stepper_step_dir_pulse_generator.sv
tb/sv/tb_stepper_step_dir_pulse_generator.sv
